/* hw/rtl/id3x_pkg.sv */
// ----------------------------------------------------------------------------
// id3x_pkg
// Shared types, constants and the helper function of the tag text extractor.
// ----------------------------------------------------------------------------
package id3x_pkg;

  // Bytes of the tag header that are skipped before the first frame.
  localparam int HEADER_BYTES = 10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_FRAMES_TO_READ = 1'b0;
  localparam logic [3:0] FRAMES_TO_READ_RESET = 4'd6;

  localparam logic [31:0] FRAME_ID_BYTES = 32'd4;
  localparam logic [31:0] SIZE_BYTES     = 32'd4;
  localparam logic [31:0] FLAG_BYTES     = 32'd2;

  // Internal frame kind: zero is an unknown frame, known frames are 1 to 6.
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam int NUM_KNOWN = 6;

  // Output codes of frame_kind.
  localparam logic [2:0] FK_TITLE   = 3'd0;
  localparam logic [2:0] FK_ARTIST  = 3'd1;
  localparam logic [2:0] FK_ALBUM   = 3'd2;
  localparam logic [2:0] FK_YEAR    = 3'd3;
  localparam logic [2:0] FK_CONTENT = 3'd4;
  localparam logic [2:0] FK_COMMENT = 3'd5;

  localparam logic [31:0] KNOWN_IDS [NUM_KNOWN] = '{
    32'h5449_5432,  // TIT2
    32'h5450_4531,  // TPE1
    32'h5441_4C42,  // TALB
    32'h5459_4552,  // TYER
    32'h5443_4F4E,  // TCON
    32'h434F_4D4D   // COMM
  };

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_IDENT   = 6'b000010,
    PH_SIZE    = 6'b000100,
    PH_FLAGS   = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  // One accepted input beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       file_start;
  } in_beat_t;

  // Map a 4-byte identifier to the internal frame kind.
  function automatic logic [2:0] kind_of(input logic [31:0] ident);
    logic [2:0] kind;
    kind = KIND_UNKNOWN;
    for (int i = 0; i < NUM_KNOWN; i++) begin
      if (ident == KNOWN_IDS[i]) begin
        kind = 3'(i + 1);
      end
    end
    return kind;
  endfunction

endpackage

/* hw/rtl/id3x_stream_if.sv */
// ----------------------------------------------------------------------------
// id3x_stream_if
// Valid/ready channels for file bytes in and extracted text out.
// ----------------------------------------------------------------------------
interface id3x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface id3x_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_kind;
  logic [7:0] text_byte;
  logic       byte_valid;
  logic       frame_end;

  modport source (output valid, output frame_kind, output text_byte,
                  output byte_valid, output frame_end, input ready);
  modport sink   (input valid, input frame_kind, input text_byte,
                  input byte_valid, input frame_end, output ready);
endinterface

/* hw/rtl/id3x_cfg_regs.sv */
// ----------------------------------------------------------------------------
// id3x_cfg_regs
// APB register file holding the frame limit.
// ----------------------------------------------------------------------------
module id3x_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [id3x_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [id3x_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [id3x_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [3:0]                     frames_to_read
);

  logic sel_limit;

  // Word index is the address bit above the byte offset.
  assign sel_limit = (paddr[2] == id3x_pkg::REG_FRAMES_TO_READ);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_read <= id3x_pkg::FRAMES_TO_READ_RESET;
    end else if (psel && penable && pwrite && sel_limit) begin
      frames_to_read <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = {{(id3x_pkg::CFG_DATA_W-4){1'b0}}, frames_to_read};
    end
  end

endmodule

/* hw/rtl/id3x_in_stage.sv */
// ----------------------------------------------------------------------------
// id3x_in_stage
// Input register that holds one file byte until the parser takes it.
// ----------------------------------------------------------------------------
module id3x_in_stage (
  input  logic               clk,
  input  logic               rst,
  id3x_in_if.sink            file_bytes,
  input  logic               take,
  output id3x_pkg::in_beat_t beat
);

  logic load;

  assign file_bytes.ready = !beat.valid || take;
  assign load = file_bytes.valid && file_bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (load) begin
      beat.valid <= 1'b1;
    end else if (take) begin
      beat.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat.data_byte  <= file_bytes.data_byte;
      beat.file_start <= file_bytes.file_start;
    end
  end

endmodule

/* hw/rtl/id3x_parser.sv */
// ----------------------------------------------------------------------------
// id3x_parser
// Tag walker state and result register; one held byte is consumed per cycle unless the result register is stalled.
// ----------------------------------------------------------------------------
module id3x_parser (
  input  logic               clk,
  input  logic               rst,
  input  id3x_pkg::in_beat_t beat,
  input  logic [3:0]         frames_to_read,
  output logic               take,
  id3x_out_if.source         tag_text
);

  localparam id3x_pkg::phase_t START_PHASE =
    (id3x_pkg::HEADER_BYTES > 0) ? id3x_pkg::PH_HEADER : id3x_pkg::PH_IDENT;

  id3x_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] ident_shift, ident_shift_next;
  logic [31:0] payload_size, payload_size_next;
  logic [3:0]  frames_done, frames_done_next;
  logic [2:0]  current_kind, current_kind_next;
  logic        terminator_seen, terminator_seen_next;

  id3x_pkg::phase_t c_phase;
  logic [31:0] c_count, c_ident, c_size, cnt_inc, shifted;
  logic [3:0]  c_done;
  logic [2:0]  c_kind, kind_code;
  logic        c_term, last;
  logic [4:0]  done_inc, limit;

  logic       res;
  logic [7:0] res_byte;
  logic       res_valid, res_end;

  assign take = beat.valid && (!tag_text.valid || tag_text.ready);

  always_comb begin
    // A file start restarts parsing before this byte is examined.
    c_phase = beat.file_start ? START_PHASE : phase;
    c_count = beat.file_start ? '0 : byte_count;
    c_ident = beat.file_start ? '0 : ident_shift;
    c_size  = beat.file_start ? '0 : payload_size;
    c_done  = beat.file_start ? '0 : frames_done;
    c_kind  = beat.file_start ? id3x_pkg::KIND_UNKNOWN : current_kind;
    c_term  = beat.file_start ? 1'b0 : terminator_seen;

    cnt_inc   = c_count + 32'd1;
    shifted   = {c_ident[23:0], beat.data_byte};
    last      = (c_count == c_size - 32'd1);
    kind_code = c_kind - 3'd1;
    done_inc  = {1'b0, c_done} + 5'd1;
    limit     = (frames_to_read == 4'd0) ? 5'd16 : {1'b0, frames_to_read};

    phase_next           = c_phase;
    byte_count_next      = c_count;
    ident_shift_next     = c_ident;
    payload_size_next    = c_size;
    frames_done_next     = c_done;
    current_kind_next    = c_kind;
    terminator_seen_next = c_term;
    res       = 1'b0;
    res_byte  = 8'd0;
    res_valid = 1'b0;
    res_end   = 1'b0;

    unique case (c_phase)
      id3x_pkg::PH_HEADER: begin
        if (cnt_inc >= 32'(id3x_pkg::HEADER_BYTES)) begin
          phase_next      = id3x_pkg::PH_IDENT;
          byte_count_next = '0;
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      id3x_pkg::PH_IDENT: begin
        if (cnt_inc >= id3x_pkg::FRAME_ID_BYTES) begin
          current_kind_next = id3x_pkg::kind_of(shifted);
          ident_shift_next  = '0;
          byte_count_next   = '0;
          phase_next        = id3x_pkg::PH_SIZE;
        end else begin
          ident_shift_next = shifted;
          byte_count_next  = cnt_inc;
        end
      end
      id3x_pkg::PH_SIZE: begin
        if (cnt_inc >= id3x_pkg::SIZE_BYTES) begin
          payload_size_next = shifted;
          ident_shift_next  = '0;
          byte_count_next   = '0;
          phase_next        = id3x_pkg::PH_FLAGS;
        end else begin
          ident_shift_next = shifted;
          byte_count_next  = cnt_inc;
        end
      end
      id3x_pkg::PH_FLAGS: begin
        if (cnt_inc >= id3x_pkg::FLAG_BYTES) begin
          byte_count_next      = '0;
          terminator_seen_next = 1'b0;
          if (c_size == 32'd0) begin
            frames_done_next  = done_inc[3:0];
            current_kind_next = id3x_pkg::KIND_UNKNOWN;
            phase_next = (done_inc >= limit) ? id3x_pkg::PH_DONE : id3x_pkg::PH_IDENT;
          end else begin
            phase_next = id3x_pkg::PH_PAYLOAD;
          end
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      id3x_pkg::PH_PAYLOAD: begin
        if (c_kind != id3x_pkg::KIND_UNKNOWN) begin
          if (c_count == 32'd0) begin
            // Encoding byte: only reported when it closes the frame.
            res     = last;
            res_end = 1'b1;
          end else if (!c_term && beat.data_byte != 8'd0) begin
            res       = 1'b1;
            res_byte  = beat.data_byte;
            res_valid = 1'b1;
            res_end   = last;
          end else begin
            terminator_seen_next = 1'b1;
            res     = last;
            res_end = 1'b1;
          end
        end
        if (last) begin
          frames_done_next     = done_inc[3:0];
          byte_count_next      = '0;
          current_kind_next    = id3x_pkg::KIND_UNKNOWN;
          terminator_seen_next = 1'b0;
          phase_next = (done_inc >= limit) ? id3x_pkg::PH_DONE : id3x_pkg::PH_IDENT;
        end else begin
          byte_count_next = cnt_inc;
        end
      end
      id3x_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= START_PHASE;
      byte_count      <= '0;
      ident_shift     <= '0;
      payload_size    <= '0;
      frames_done     <= '0;
      current_kind    <= id3x_pkg::KIND_UNKNOWN;
      terminator_seen <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      ident_shift     <= ident_shift_next;
      payload_size    <= payload_size_next;
      frames_done     <= frames_done_next;
      current_kind    <= current_kind_next;
      terminator_seen <= terminator_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_text.valid <= 1'b0;
    end else if (take) begin
      tag_text.valid <= res;
    end else if (tag_text.ready) begin
      tag_text.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res) begin
      tag_text.frame_kind <= kind_code;
      tag_text.text_byte  <= res_byte;
      tag_text.byte_valid <= res_valid;
      tag_text.frame_end  <= res_end;
    end
  end

endmodule

/* hw/rtl/id3x_frame_text_extractor_core.sv */
// ----------------------------------------------------------------------------
// id3_frame_text_extractor_core
// Walks the tag at the head of an audio file and streams out frame text.
// ----------------------------------------------------------------------------
// File bytes arrive one per beat on file_bytes; file_start on a beat marks
// the first byte of a new file and restarts the tag walk at that byte.
// Each text beat on tag_text carries the frame kind (title, artist, album,
// year, content type or comment), one text character with byte_valid set,
// or a zero filler with byte_valid clear, and frame_end on the frame's last
// payload byte. Bytes of other frames, of the header and of the frame
// headers produce no beat.
// The limit on parsed frames sits in one APB register at address 0 (zero
// means sixteen frames); write it only while the block is idle.
// A byte accepted from file_bytes is held in the input register, parsed
// from there and, if it yields text, registered in the result register
// that drives tag_text. One byte is accepted every cycle while tag_text
// is taken every cycle; the bound is the single parse step between the
// input and result registers.
// When the receiver stalls, the pending result holds and the input register
// keeps one more byte, after which file_bytes.ready drops.
// Reset clears both registers, restores the limit to six frames and puts
// the walker at the start of the tag header.
// ----------------------------------------------------------------------------
module id3_frame_text_extractor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [id3x_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [id3x_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [id3x_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  id3x_in_if.sink                        file_bytes,
  id3x_out_if.source                     tag_text
);

  logic [3:0]         frames_to_read;
  logic               take;
  id3x_pkg::in_beat_t beat;

  id3x_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frames_to_read (frames_to_read)
  );

  // Input register: decouples the byte source from a stalled receiver.
  id3x_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .file_bytes (file_bytes),
    .take       (take),
    .beat       (beat)
  );

  // Parse step and result register.
  id3x_parser u_parse (
    .clk            (clk),
    .rst            (rst),
    .beat           (beat),
    .frames_to_read (frames_to_read),
    .take           (take),
    .tag_text       (tag_text)
  );

  // A beat without text is always the closing filler of a frame.
  a_filler_ends_frame: assert property (@(posedge clk) disable iff (rst)
    tag_text.valid && !tag_text.byte_valid |-> tag_text.frame_end)
    else $error("text filler beat without frame_end");

  // Text characters are never the terminating zero.
  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    tag_text.valid && tag_text.byte_valid |-> tag_text.text_byte != 8'd0)
    else $error("zero byte reported as text");

  // Only the six known kinds are reported.
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    tag_text.valid |-> tag_text.frame_kind <= id3x_pkg::FK_COMMENT)
    else $error("frame_kind out of range");

  // Nothing is pending on either side right after reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !tag_text.valid && file_bytes.ready)
    else $error("result or input stage not cleared by reset");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tag text extractor testbench
// Feeds whole tagged files, mostly well formed with random frame content,
// into the extractor. Every accepted byte runs through an internal model of
// the tag walk, and each text beat that the block sends is checked field by
// field against the oldest predicted beat. Both sides of the stream stall at
// random, and the frame limit register is rewritten between idle phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ITEMS_TARGET = 1350;
  localparam int IDLE_PCT [4] = '{0, 10, 35, 70};
  localparam logic [id3x_pkg::CFG_ADDR_W-1:0] LIMIT_ADDR =
    id3x_pkg::CFG_ADDR_W'(4 * id3x_pkg::REG_FRAMES_TO_READ);

  // Identifiers of the six text frames, in frame_kind order.
  localparam logic [31:0] TEXT_IDS [6] = '{"TIT2", "TPE1", "TALB", "TYER", "TCON", "COMM"};
  localparam logic [2:0] KIND_CODE [6] = '{id3x_pkg::FK_TITLE, id3x_pkg::FK_ARTIST,
                                           id3x_pkg::FK_ALBUM, id3x_pkg::FK_YEAR,
                                           id3x_pkg::FK_CONTENT, id3x_pkg::FK_COMMENT};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } file_byte_t;

  typedef struct packed {
    logic [2:0] frame_kind;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       frame_end;
  } text_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel, penable, pwrite, pready;
  logic [id3x_pkg::CFG_ADDR_W-1:0] paddr;
  logic [id3x_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  id3x_in_if  file_bytes_if ();
  id3x_out_if tag_text_if ();

  id3_frame_text_extractor_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .file_bytes(file_bytes_if),
    .tag_text(tag_text_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  file_byte_t pending_bytes [$];
  text_beat_t expected_text [$];
  int         items_queued = 0;
  int         err_count = 0;
  int         in_gap_pct = 0;
  int         out_stall_pct = 0;
  bit         holding = 1'b0;

  // Model of the tag walk.
  logic [3:0]        limit_cfg;
  id3x_pkg::phase_t  walk_phase;
  logic [31:0]       walk_cnt;
  logic [31:0]       walk_shift;
  logic [31:0]       walk_size;
  logic [3:0]        frames_seen;
  int                text_sel;
  logic              zero_seen;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic int pick_len();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic restart_walk();
    walk_phase  = id3x_pkg::PH_HEADER;
    walk_cnt    = '0;
    walk_shift  = '0;
    walk_size   = '0;
    frames_seen = '0;
    text_sel    = -1;
    zero_seen   = 1'b0;
  endtask

  task automatic end_of_frame();
    logic [4:0] lim;
    logic [4:0] done_inc;
    lim = (limit_cfg == 4'd0) ? 5'd16 : {1'b0, limit_cfg};
    done_inc = {1'b0, frames_seen} + 5'd1;
    frames_seen = done_inc[3:0];
    walk_cnt  = '0;
    text_sel  = -1;
    zero_seen = 1'b0;
    walk_phase = (done_inc >= lim) ? id3x_pkg::PH_DONE : id3x_pkg::PH_IDENT;
  endtask

  // Advances the model by one file byte and queues the text beat it yields.
  task automatic walk_tag_byte(input file_byte_t fb);
    logic       last;
    logic       emit;
    text_beat_t beat;
    emit = 1'b0;
    beat = '0;
    if (fb.file_start) begin
      restart_walk();
    end
    case (walk_phase)
      id3x_pkg::PH_HEADER: begin
        walk_cnt++;
        if (walk_cnt >= id3x_pkg::HEADER_BYTES) begin
          walk_phase = id3x_pkg::PH_IDENT;
          walk_cnt = '0;
        end
      end
      id3x_pkg::PH_IDENT: begin
        walk_shift = {walk_shift[23:0], fb.data_byte};
        walk_cnt++;
        if (walk_cnt >= 4) begin
          text_sel = -1;
          for (int i = 0; i < 6; i++) begin
            if (walk_shift == TEXT_IDS[i]) begin
              text_sel = i;
            end
          end
          walk_shift = '0;
          walk_cnt = '0;
          walk_phase = id3x_pkg::PH_SIZE;
        end
      end
      id3x_pkg::PH_SIZE: begin
        walk_shift = {walk_shift[23:0], fb.data_byte};
        walk_cnt++;
        if (walk_cnt >= 4) begin
          walk_size = walk_shift;
          walk_shift = '0;
          walk_cnt = '0;
          walk_phase = id3x_pkg::PH_FLAGS;
        end
      end
      id3x_pkg::PH_FLAGS: begin
        walk_cnt++;
        if (walk_cnt >= 2) begin
          walk_cnt = '0;
          zero_seen = 1'b0;
          if (walk_size == 0) begin
            end_of_frame();
          end else begin
            walk_phase = id3x_pkg::PH_PAYLOAD;
          end
        end
      end
      id3x_pkg::PH_PAYLOAD: begin
        last = (walk_cnt == walk_size - 32'd1);
        if (text_sel >= 0) begin
          // The encoding byte, a zero byte and anything after the zero only
          // show up as a filler beat when they close the frame.
          if (walk_cnt == 0) begin
            emit = last;
            beat = '{KIND_CODE[text_sel], 8'h00, 1'b0, 1'b1};
          end else if (!zero_seen && fb.data_byte != 8'h00) begin
            emit = 1'b1;
            beat = '{KIND_CODE[text_sel], fb.data_byte, 1'b1, last};
          end else begin
            zero_seen = 1'b1;
            emit = last;
            beat = '{KIND_CODE[text_sel], 8'h00, 1'b0, 1'b1};
          end
        end
        if (last) begin
          end_of_frame();
        end else begin
          walk_cnt++;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      expected_text.push_back(beat);
    end
  endtask

  // Sender: one byte on the bus at a time, with random gaps between bytes.
  always @(posedge clk) begin
    file_byte_t cur_byte;
    int         gap_left;
    if (rst) begin
      file_bytes_if.valid <= 1'b0;
      holding = 1'b0;
      gap_left = 0;
    end else begin
      if (file_bytes_if.valid && file_bytes_if.ready) begin
        walk_tag_byte(cur_byte);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          cur_byte = pending_bytes.pop_front();
          holding = 1'b1;
          if ($urandom_range(99) < in_gap_pct) begin
            gap_left = pick_len();
          end
        end
      end
      file_bytes_if.valid      <= holding;
      file_bytes_if.data_byte  <= cur_byte.data_byte;
      file_bytes_if.file_start <= cur_byte.file_start;
    end
  end

  // Receiver: checks each text beat and stalls at random.
  always @(posedge clk) begin
    text_beat_t want;
    int         stall_left;
    logic       rdy;
    if (rst) begin
      tag_text_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tag_text_if.valid && tag_text_if.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("text beat with no beat expected");
        end else begin
          want = expected_text.pop_front();
          if (tag_text_if.frame_kind !== want.frame_kind) begin
            report_mismatch($sformatf("frame_kind %0d, expected %0d",
                                      tag_text_if.frame_kind, want.frame_kind));
          end
          if (tag_text_if.text_byte !== want.text_byte) begin
            report_mismatch($sformatf("text_byte %h, expected %h",
                                      tag_text_if.text_byte, want.text_byte));
          end
          if (tag_text_if.byte_valid !== want.byte_valid) begin
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      tag_text_if.byte_valid, want.byte_valid));
          end
          if (tag_text_if.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      tag_text_if.frame_end, want.frame_end));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(99) < out_stall_pct) begin
        stall_left = pick_len() - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      tag_text_if.ready <= rdy;
    end
  end

  task automatic queue_file_byte(input logic [7:0] b, input logic fs, input bit counted = 1'b1);
    pending_bytes.push_back('{b, fs});
    if (counted) begin
      items_queued++;
    end
  endtask

  task automatic queue_frame_head(input logic [31:0] id, input logic [31:0] size);
    for (int i = 3; i >= 0; i--) begin
      queue_file_byte(id[8*i +: 8], 1'b0);
    end
    for (int i = 3; i >= 0; i--) begin
      queue_file_byte(size[8*i +: 8], 1'b0);
    end
    repeat (2) queue_file_byte(8'($urandom), 1'b0);
  endtask

  // Queues a file of random frames. A clean file has no cut and no trailing
  // bytes, so that a later phase can carry on with its frames.
  task automatic queue_tag_file(input bit fresh, input int nframes, input bit clean);
    int          sel;
    int          zpos;
    logic [31:0] id;
    logic [31:0] size;
    logic [7:0]  b;
    if (fresh) begin
      queue_file_byte(8'($urandom), 1'b1);
      repeat (id3x_pkg::HEADER_BYTES - 1) queue_file_byte(8'($urandom), 1'b0);
    end
    for (int f = 0; f < nframes; f++) begin
      sel = $urandom_range(99);
      id = TEXT_IDS[$urandom_range(5)];
      if (sel >= 80) begin
        id = $urandom;
      end else if (sel >= 65) begin
        id[8*$urandom_range(3) +: 8] ^= 8'($urandom_range(1, 255));
      end
      // A file broken off inside a frame identifier.
      if (!clean && $urandom_range(49) == 0) begin
        for (int i = 3; i > $urandom_range(1, 3); i--) begin
          queue_file_byte(id[8*i +: 8], 1'b0);
        end
        return;
      end
      sel = $urandom_range(99);
      if (sel < 10) begin
        size = '0;
      end else if (sel < 80) begin
        size = $urandom_range(1, 12);
      end else if (sel < 95 || clean) begin
        size = $urandom_range(13, 40);
      end else begin
        size = $urandom | 32'h0000_0100;
      end
      queue_frame_head(id, size);
      // A huge size field: the file ends long before the payload does.
      if (size > 40) begin
        repeat ($urandom_range(0, 20)) queue_file_byte(8'($urandom), 1'b0);
        return;
      end
      zpos = ($urandom_range(2) == 0) ? int'($urandom_range(1, size)) : -1;
      for (int i = 0; i < size; i++) begin
        if (i == 0) begin
          b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        end else if (i == zpos) begin
          b = 8'h00;
        end else if ($urandom_range(9) == 0) begin
          b = 8'($urandom);
        end else begin
          b = 8'($urandom_range(32, 126));
        end
        queue_file_byte(b, 1'b0);
      end
    end
    if (!clean) begin
      repeat ($urandom_range(0, 4)) queue_file_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || holding || expected_text.size() != 0) begin
      @(posedge clk);
    end
    // A trailing byte that yields no beat may still sit in the pipeline.
    repeat (8) @(posedge clk);
  endtask

  // Writes the frame limit, then reads it back. Upper data bits are noise.
  task automatic cfg_write(input logic [3:0] val);
    logic [id3x_pkg::CFG_DATA_W-1:0] wd;
    wd = id3x_pkg::CFG_DATA_W'($urandom);
    wd[3:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_cfg = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[3:0] !== val) begin
      report_mismatch($sformatf("frame limit reads %h, expected %h", prdata[3:0], val));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [3:0] lim;
    int         phase_no;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    file_bytes_if.valid = 1'b0;
    file_bytes_if.data_byte = '0;
    file_bytes_if.file_start = 1'b0;
    tag_text_if.ready = 1'b0;
    limit_cfg = id3x_pkg::FRAMES_TO_READ_RESET;
    restart_walk();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed file under the reset limit of six frames: an encoding byte
    // that closes its frame, a zero-size frame, text after a zero byte, high
    // character codes, a zero on the last byte, plain text, then bytes past
    // the limit that must be ignored.
    in_gap_pct = 10;
    out_stall_pct = 10;
    queue_file_byte(8'h49, 1'b1);
    repeat (id3x_pkg::HEADER_BYTES - 1) queue_file_byte(8'h00, 1'b0);
    queue_frame_head("TIT2", 32'd1);
    queue_file_byte(8'h03, 1'b0);
    queue_frame_head("COMM", 32'd0);
    queue_frame_head("TALB", 32'd4);
    queue_file_byte(8'h00, 1'b0);
    queue_file_byte("A", 1'b0);
    queue_file_byte(8'h00, 1'b0);
    queue_file_byte("B", 1'b0);
    queue_frame_head("TYER", 32'd3);
    queue_file_byte(8'hFF, 1'b0);
    queue_file_byte(8'hFF, 1'b0);
    queue_file_byte(8'h80, 1'b0);
    queue_frame_head("TCON", 32'd2);
    queue_file_byte(8'h01, 1'b0);
    queue_file_byte(8'h00, 1'b0);
    queue_frame_head("TPE1", 32'd2);
    queue_file_byte(8'h00, 1'b0);
    queue_file_byte("z", 1'b0);
    queue_file_byte("T", 1'b0, 1'b0);
    queue_file_byte("I", 1'b0, 1'b0);

    // Random phases. The first few pin the limit at its extremes, including
    // zero for sixteen frames, and lower it below the frames already parsed
    // in a file that is still open.
    phase_no = 0;
    while (items_queued < ITEMS_TARGET) begin
      wait_drained();
      case (phase_no)
        0: lim = 4'd1;
        1: lim = 4'd15;
        2: lim = 4'd0;
        3: lim = 4'd15;
        4: lim = 4'd3;
        default: lim = 4'($urandom);
      endcase
      cfg_write(lim);
      in_gap_pct = IDLE_PCT[$urandom_range(3)];
      out_stall_pct = IDLE_PCT[$urandom_range(3)];
      if (phase_no == 3) begin
        queue_tag_file(1'b1, 8, 1'b1);
      end else if (phase_no == 4) begin
        queue_tag_file(1'b0, 4, 1'b0);
      end else begin
        repeat ($urandom_range(2, 4)) begin
          queue_tag_file(1'b1, $urandom_range(1, ((lim == 4'd0) ? 16 : lim) + 2), 1'b0);
        end
      end
      phase_no++;
    end

    wait_drained();
    if (err_count == 0) begin
      $display("** id3_frame_text_extractor_core: PASSED **");
    end else begin
      $display("** id3_frame_text_extractor_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("timeout with %0d bytes and %0d beats outstanding",
             pending_bytes.size(), expected_text.size());
    $display("** id3_frame_text_extractor_core: FAILED **");
    $finish;
  end

endmodule
